[sv/hfr_pkg.sv]
// Shared request, response and control types for the hierarchy flag resolver.
`timescale 1ns / 1ps

package hfr_pkg;

	// Request mode codes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Response status codes.
	localparam logic [2:0] ST_OK             = 3'd0;
	localparam logic [2:0] ST_INVALID_DOC    = 3'd1;
	localparam logic [2:0] ST_MISSING_OBJ    = 3'd2;
	localparam logic [2:0] ST_MISSING_PARENT = 3'd3;
	localparam logic [2:0] ST_CYCLE          = 3'd4;
	localparam logic [2:0] ST_DEPTH          = 3'd5;

	// One input request.
	typedef struct packed {
		logic        mode;
		logic [5:0]  slot;
		logic        entry_valid;
		logic [31:0] entry_id;
		logic        entry_has_parent;
		logic [31:0] entry_parent_id;
		logic        entry_visible;
		logic        entry_locked;
		logic [31:0] object_id;
	} req_t;

	// One response.
	typedef struct packed {
		logic [2:0]  status;
		logic        resolved;
		logic        effectively_visible;
		logic        effectively_locked;
		logic        hidden_found;
		logic [31:0] hidden_by_id;
		logic        locked_found;
		logic [31:0] locked_by_id;
		logic [4:0]  chain_depth;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       take;
		logic       clr_step;
		logic       lk_start;
		logic       lk_run;
		logic       cur_load;
		logic       vs_start;
		logic       vs_run;
		logic       node_commit;
		logic       fin_set;
		logic [2:0] fin_code;
		logic       publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic doc_valid;
		logic req_query;
		logic clr_last;
		logic lk_hit;
		logic lk_miss;
		logic first;
		logic vs_seen;
		logic vs_clear;
		logic cnt_full;
		logic has_parent;
		logic out_free;
	} sts_t;

endpackage

[sv/hfr_ctrl.sv]
// Controller state machine that sequences table clearing, lookups and chain walks.
`timescale 1ns / 1ps

module hfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hfr_pkg::sts_t sts,
	output hfr_pkg::cmd_t cmd
);
	import hfr_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_LOOKUP = 5'b00100,
		S_VCHECK = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (sts.req_query) begin
						if (!sts.doc_valid) begin
							cmd.fin_set  = 1'b1;
							cmd.fin_code = ST_INVALID_DOC;
							state_d      = S_DONE;
						end else begin
							cmd.lk_start = 1'b1;
							state_d      = S_LOOKUP;
						end
					end
				end
			end
			S_LOOKUP: begin
				if (sts.lk_hit) begin
					cmd.cur_load = 1'b1;
					cmd.vs_start = 1'b1;
					state_d      = S_VCHECK;
				end else if (sts.lk_miss) begin
					cmd.fin_set  = 1'b1;
					cmd.fin_code = sts.first ? ST_MISSING_OBJ : ST_MISSING_PARENT;
					state_d      = S_DONE;
				end else begin
					cmd.lk_run = 1'b1;
				end
			end
			S_VCHECK: begin
				if (sts.vs_seen) begin
					cmd.fin_set  = 1'b1;
					cmd.fin_code = ST_CYCLE;
					state_d      = S_DONE;
				end else if (sts.vs_clear) begin
					if (sts.cnt_full) begin
						cmd.fin_set  = 1'b1;
						cmd.fin_code = ST_DEPTH;
						state_d      = S_DONE;
					end else begin
						cmd.node_commit = 1'b1;
						if (!sts.has_parent) begin
							cmd.fin_set  = 1'b1;
							cmd.fin_code = ST_OK;
							state_d      = S_DONE;
						end else begin
							cmd.lk_start = 1'b1;
							state_d      = S_LOOKUP;
						end
					end
				end else begin
					cmd.vs_run = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[sv/hfr_datapath.sv]
// Datapath with the object table, visited list, walk registers and response register.
`timescale 1ns / 1ps

module hfr_datapath #(
	parameter int TABLE_ENTRIES = 64,
	parameter int DEPTH_CAP     = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hfr_pkg::cmd_t cmd,
	output hfr_pkg::sts_t sts,
	input  hfr_pkg::req_t in_data,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	output logic          out_valid,
	input  logic          out_ready,
	output hfr_pkg::rsp_t out_data
);
	import hfr_pkg::*;

	localparam int AW      = $clog2(TABLE_ENTRIES);
	localparam int TW      = AW + 1;
	localparam int CNT_MAX = DEPTH_CAP + 1;
	localparam int CW      = $clog2(DEPTH_CAP + 2);
	localparam int VW      = $clog2(DEPTH_CAP + 1);

	typedef struct packed {
		logic        used;
		logic [31:0] id;
		logic        has_parent;
		logic [31:0] parent_id;
		logic        visible;
		logic        locked;
	} tbl_t;

	tbl_t        tbl_mem [TABLE_ENTRIES];
	logic [31:0] vis_mem [CNT_MAX];

	logic          doc_valid_q;
	logic [AW-1:0] clr_q;
	logic [TW-1:0] lk_addr_q;
	logic          rdv_s1;
	logic          rd_last_s1;
	tbl_t          rd_s1;
	tbl_t          cur_q;
	logic [31:0]   target_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] vaddr_q;
	logic          vv_s1;
	logic          vlast_s1;
	logic [31:0]   vrd_s1;
	logic          hf_q;
	logic [31:0]   hid_q;
	logic          lf_q;
	logic [31:0]   lid_q;
	logic [2:0]    stat_q;
	logic          out_valid_q;
	rsp_t          out_q;
	rsp_t          rsp_d;

	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	tbl_t          tbl_wdata;
	logic          tbl_re;
	logic          vs_re;
	logic          lk_hit;
	logic          vs_seen;

	// Table write port: the clearing pass after reset, or a write request.
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = clr_q;
		tbl_wdata = '0;
		if (cmd.clr_step) begin
			tbl_we = 1'b1;
		end else if (cmd.take && in_data.mode == MODE_WRITE &&
			32'(in_data.slot) < 32'(TABLE_ENTRIES)) begin
			tbl_we               = 1'b1;
			tbl_waddr            = AW'(in_data.slot);
			tbl_wdata.used       = in_data.entry_valid;
			tbl_wdata.id         = in_data.entry_id;
			tbl_wdata.has_parent = in_data.entry_has_parent;
			tbl_wdata.parent_id  = in_data.entry_parent_id;
			tbl_wdata.visible    = in_data.entry_visible;
			tbl_wdata.locked     = in_data.entry_locked;
		end
	end

	assign tbl_re = cmd.lk_run && (lk_addr_q < TW'(TABLE_ENTRIES));
	assign vs_re  = cmd.vs_run && (vaddr_q < count_q);

	// Object table memory with a registered read.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			rd_s1      <= tbl_mem[lk_addr_q[AW-1:0]];
			rd_last_s1 <= (lk_addr_q == TW'(TABLE_ENTRIES - 1));
		end
	end

	// Visited id list with a registered read.
	always_ff @(posedge clk) begin
		if (cmd.node_commit) begin
			vis_mem[count_q[VW-1:0]] <= cur_q.id;
		end
		if (vs_re) begin
			vrd_s1   <= vis_mem[vaddr_q[VW-1:0]];
			vlast_s1 <= (vaddr_q == count_q - CW'(1));
		end
	end

	// Scan comparisons.
	assign lk_hit  = rdv_s1 && rd_s1.used && (rd_s1.id == target_q);
	assign vs_seen = vv_s1 && (vrd_s1 == cur_q.id);

	// Status back to the controller.
	always_comb begin
		sts            = '0;
		sts.doc_valid  = doc_valid_q;
		sts.req_query  = (in_data.mode == MODE_QUERY);
		sts.clr_last   = (clr_q == AW'(TABLE_ENTRIES - 1));
		sts.lk_hit     = lk_hit;
		sts.lk_miss    = rdv_s1 && rd_last_s1 && !lk_hit;
		sts.first      = (count_q == '0);
		sts.vs_seen    = vs_seen;
		sts.vs_clear   = !vs_seen && ((vv_s1 && vlast_s1) || (count_q == '0));
		sts.cnt_full   = (count_q == CW'(CNT_MAX));
		sts.has_parent = cur_q.has_parent;
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Control registers: configuration, counters and scan valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_valid_q <= 1'b1;
			clr_q       <= '0;
			lk_addr_q   <= '0;
			rdv_s1      <= 1'b0;
			vaddr_q     <= '0;
			vv_s1       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				doc_valid_q <= cfg_wdata;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.lk_start) begin
				lk_addr_q <= '0;
				rdv_s1    <= 1'b0;
			end else begin
				rdv_s1 <= tbl_re;
				if (tbl_re) begin
					lk_addr_q <= lk_addr_q + TW'(1);
				end
			end
			if (cmd.vs_start) begin
				vaddr_q <= '0;
				vv_s1   <= 1'b0;
			end else begin
				vv_s1 <= vs_re;
				if (vs_re) begin
					vaddr_q <= vaddr_q + CW'(1);
				end
			end
			if (cmd.take) begin
				count_q <= '0;
			end else if (cmd.node_commit) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers: current node, next id to find and first hidden and locked ids.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			target_q <= in_data.object_id;
			hf_q     <= 1'b0;
			hid_q    <= '0;
			lf_q     <= 1'b0;
			lid_q    <= '0;
		end else if (cmd.node_commit) begin
			target_q <= cur_q.parent_id;
			if (!cur_q.visible && !hf_q) begin
				hf_q  <= 1'b1;
				hid_q <= cur_q.id;
			end
			if (cur_q.locked && !lf_q) begin
				lf_q  <= 1'b1;
				lid_q <= cur_q.id;
			end
		end
		if (cmd.cur_load) begin
			cur_q <= rd_s1;
		end
		if (cmd.fin_set) begin
			stat_q <= cmd.fin_code;
		end
	end

	// Response assembly from the final status.
	always_comb begin
		rsp_d        = '0;
		rsp_d.status = stat_q;
		case (stat_q) inside
			ST_OK: begin
				rsp_d.resolved            = 1'b1;
				rsp_d.effectively_visible = !hf_q;
				rsp_d.effectively_locked  = lf_q;
				rsp_d.hidden_found        = hf_q;
				rsp_d.hidden_by_id        = hid_q;
				rsp_d.locked_found        = lf_q;
				rsp_d.locked_by_id        = lid_q;
				rsp_d.chain_depth         = 5'(count_q - CW'(1));
			end
			ST_MISSING_PARENT, ST_CYCLE, ST_DEPTH: begin
				rsp_d.effectively_locked = 1'b1;
				rsp_d.hidden_found       = hf_q;
				rsp_d.hidden_by_id       = hid_q;
				rsp_d.locked_found       = lf_q;
				rsp_d.locked_by_id       = lid_q;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_q <= rsp_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// The walk never records more nodes than the depth limit allows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CNT_MAX))
		else $error("visited count beyond the depth limit");

	// A node is only committed while the visited list still has room.
	a_commit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.node_commit |-> (count_q < CW'(CNT_MAX)))
		else $error("node committed into a full visited list");

	// A response is only loaded when the output register is free or being emptied.
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("response overwritten before it was taken");

	// A resolved response always carries the resolved status.
	a_resolved_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.resolved) |-> (out_q.status == ST_OK))
		else $error("resolved flag with a failure status");
`endif

endmodule

[sv/hierarchy_flag_resolver_top.sv]
// Top level of the hierarchy flag resolver: controller plus datapath.
// A write request is written to the table as it is taken; a query, for each node on the
// chain, scans the table through its single read port (lowest slot first), then scans
// the visited list, and its response is then registered.
// One request is worked on at a time; a waiting response does not block write requests.
// After reset the table is swept clear, slot by slot, while no request is taken.
`timescale 1ns / 1ps

module hierarchy_flag_resolver_top #(
	parameter int TABLE_ENTRIES = 64,
	parameter int DEPTH_CAP     = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hfr_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output hfr_pkg::rsp_t out_data,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);
	import hfr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencing.
	hfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Storage and compare logic.
	hfr_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.DEPTH_CAP     (DEPTH_CAP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
